// ===== rtl/core/ttt_pkg.sv =====
// ----------------------------------------------------------------------------
// ttt_pkg: shared types and constants for the temperature trend estimator
// Word formats, the shared arithmetic unit command and response, and the
// fixed widths of the wide fixed-point datapath.
// ----------------------------------------------------------------------------
package ttt_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 10;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned TEMP_W = 12;
  localparam int unsigned MIN_W  = 16;
  localparam int unsigned HELD_W = 4;

  // Wide accumulator: every sum and product of the fit fits in 96 bits signed
  localparam int unsigned ACC_W = 96;
  // Multiplier operand width, enough for the signed sum of ages
  localparam int unsigned B_W   = 40;
  localparam int unsigned NB_W  = $clog2(B_W + 1);

  // Slope threshold: 375000 * num + D < 0 means slope below -0.01 C/min
  localparam int unsigned SLOPE_K    = 375000;
  localparam int unsigned SLOPE_K_NB = 19;
  localparam int unsigned MS_PER_MIN = 60000;
  localparam int unsigned MS_MIN_NB  = 16;
  localparam int unsigned TN_NB      = 20;
  localparam int unsigned DIV_STEPS  = MIN_W + 1;

  localparam logic signed [TEMP_W-1:0] TARGET_RESET = -12'sd80;

  typedef struct packed {
    logic [TIME_W-1:0]        sample_time_ms;
    logic signed [TEMP_W-1:0] temperature;
  } in_word_t;

  typedef struct packed {
    logic              estimate_valid;
    logic [MIN_W-1:0]  minutes_to_target;
    logic [HELD_W-1:0] samples_held;
  } out_word_t;

  typedef enum logic [1:0] {
    ALU_MAC = 2'b01,
    ALU_DIV = 2'b10
  } alu_op_e;

  // MAC: res = c +/- a * b, b taken over nb bits, signed or unsigned
  // DIV: res = a / c in MIN_W bits, saturated
  typedef struct packed {
    alu_op_e          op;
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] c;
    logic [B_W-1:0]   b;
    logic [NB_W-1:0]  nb;
    logic             b_signed;
    logic             neg;
  } alu_cmd_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] res;
  } alu_rsp_t;

endpackage

// ===== rtl/core/ttt_window.sv =====
// ----------------------------------------------------------------------------
// ttt_window: ring of the most recent samples
// Holds timestamps and temperatures, the write slot and the fill count.
// ----------------------------------------------------------------------------
module ttt_window import ttt_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH),
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [TIME_W-1:0]        wr_time_i,
  input  logic signed [TEMP_W-1:0] wr_temp_i,
  input  logic [SLOT_W-1:0]        rd_idx_i,
  output logic [TIME_W-1:0]        rd_time_o,
  output logic signed [TEMP_W-1:0] rd_temp_o,
  output logic [FILL_W-1:0]        fill_o
);

  logic [TIME_W-1:0]        time_q [WINDOW_DEPTH];
  logic signed [TEMP_W-1:0] temp_q [WINDOW_DEPTH];
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic [FILL_W-1:0]        fill_q, fill_d;

  always_comb begin
    slot_d = slot_q;
    fill_d = fill_q;
    if (wr_en_i) begin
      // advance and wrap the write slot, saturate the fill count
      slot_d = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
      if (fill_q != FILL_W'(WINDOW_DEPTH)) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
    end else begin
      slot_q <= slot_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      time_q[slot_q] <= wr_time_i;
      temp_q[slot_q] <= wr_temp_i;
    end
  end

  assign rd_time_o = time_q[rd_idx_i];
  assign rd_temp_o = temp_q[rd_idx_i];
  assign fill_o    = fill_q;

endmodule

// ===== rtl/core/ttt_alu.sv =====
// ----------------------------------------------------------------------------
// ttt_alu: shared wide add/subtract unit
// Serial shift-add multiply-accumulate and restoring division, one bit a cycle.
// ----------------------------------------------------------------------------
module ttt_alu import ttt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  alu_cmd_t cmd_i,
  output alu_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             div_q, div_d;
  logic             sat_q, sat_d;
  logic             sgn_q, sgn_d;
  logic             neg_q, neg_d;
  logic             done_q, done_d;
  logic [NB_W-1:0]  cnt_q, cnt_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] m_q, m_d;
  logic [B_W-1:0]   r_q, r_d;
  logic [MIN_W-1:0] quo_q, quo_d;

  logic             last;
  logic             sub;
  logic [ACC_W-1:0] sum;

  assign last = (cnt_q == NB_W'(1));
  assign sub  = div_q | (neg_q ^ (last & sgn_q));
  assign sum  = acc_q + (m_q ^ {ACC_W{sub}}) + ACC_W'(sub);

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    sat_d  = sat_q;
    sgn_d  = sgn_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    m_d    = m_q;
    r_d    = r_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      div_d  = (cmd_i.op == ALU_DIV);
      sat_d  = 1'b0;
      sgn_d  = cmd_i.b_signed;
      neg_d  = cmd_i.neg;
      r_d    = cmd_i.b;
      quo_d  = '0;
      if (cmd_i.op == ALU_DIV) begin
        acc_d = cmd_i.a;
        m_d   = cmd_i.c << MIN_W;
        cnt_d = NB_W'(DIV_STEPS);
      end else begin
        acc_d = cmd_i.c;
        m_d   = cmd_i.a;
        cnt_d = cmd_i.nb;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - NB_W'(1);
      if (div_q) begin
        m_d = m_q >> 1;
        if (cnt_q == NB_W'(DIV_STEPS)) begin
          // quotient would not fit: saturate and stop
          if (!sum[ACC_W-1]) begin
            sat_d  = 1'b1;
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end else begin
          if (!sum[ACC_W-1]) begin
            acc_d = sum;
          end
          quo_d = {quo_q[MIN_W-2:0], ~sum[ACC_W-1]};
          if (last) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
      end else begin
        if (r_q[0]) begin
          acc_d = sum;
        end
        m_d = m_q << 1;
        r_d = r_q >> 1;
        if (last) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    sat_q <= sat_d;
    sgn_q <= sgn_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    m_q   <= m_d;
    r_q   <= r_d;
    quo_q <= quo_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    if (div_q) begin
      rsp_o.res = sat_q ? ACC_W'({MIN_W{1'b1}}) : ACC_W'(quo_q);
    end else begin
      rsp_o.res = acc_q;
    end
  end

endmodule

// ===== rtl/core/temperature_trend_time_to_target.sv =====
// ----------------------------------------------------------------------------
// temperature_trend_time_to_target: least-squares trend and time to target
// Fits a line over the recent temperature window and estimates the minutes
// until the fitted line reaches the programmed target.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one word per
//   timestamped sample. Output channel (out_valid_o / out_stall_i /
//   out_data_o): exactly one result word per input word, in order.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes the
//   signed target temperature; always ready, write it only while idle.
//   Sequencing: an item runs through a sequencer that drives one shared
//   96-bit add/subtract unit, one multiplier bit per cycle. With fewer
//   than three held samples the fit is skipped and no estimate is given.
//   Throughput: one item at a time; in_stall_o stays high until the
//   result is loaded into the output register, and the next word is taken
//   while that result still waits downstream.
//   Reset: window empty, target at -5 C (-80 sixteenths). The sample store
//   itself is not cleared; only written slots are ever read.
//   Stall: a stalled result word holds in the output register; the block
//   finishes the next item and waits for the register to drain.
// ----------------------------------------------------------------------------
module temperature_trend_time_to_target import ttt_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_word_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_word_t                out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic signed [TEMP_W-1:0] cfg_data_i
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [19:0] {
    ST_IDLE  = 20'h00001,
    ST_START = 20'h00002,
    ST_AGE   = 20'h00004,
    ST_SX    = 20'h00008,
    ST_SY    = 20'h00010,
    ST_SXY   = 20'h00020,
    ST_SXX   = 20'h00040,
    ST_NUM0  = 20'h00080,
    ST_NUM1  = 20'h00100,
    ST_D0    = 20'h00200,
    ST_D1    = 20'h00400,
    ST_CHK   = 20'h00800,
    ST_TN0   = 20'h01000,
    ST_TN1   = 20'h02000,
    ST_P0    = 20'h04000,
    ST_P1    = 20'h08000,
    ST_Q0    = 20'h10000,
    ST_Q1    = 20'h20000,
    ST_DIV   = 20'h40000,
    ST_OUT   = 20'h80000
  } state_e;

  state_e state_q, state_d;

  logic                     issued_q, issued_d;
  logic [SLOT_W-1:0]        idx_q, idx_d;
  logic [TIME_W-1:0]        newest_q, newest_d;
  logic [TIME_W-1:0]        age_q, age_d;
  logic signed [TEMP_W-1:0] y_q, y_d;
  logic signed [TEMP_W-1:0] target_q;
  logic [MIN_W-1:0]         minutes_q, minutes_d;

  // fit sums and intermediate terms, all two's complement
  logic [ACC_W-1:0] sx_q, sx_d;
  logic [ACC_W-1:0] sy_q, sy_d;
  logic [ACC_W-1:0] sxy_q, sxy_d;
  logic [ACC_W-1:0] sxx_q, sxx_d;
  logic [ACC_W-1:0] num_q, num_d;
  logic [ACC_W-1:0] den_q, den_d;
  logic [ACC_W-1:0] tn_q, tn_d;
  logic [ACC_W-1:0] p_q, p_d;
  logic [ACC_W-1:0] q_q, q_d;

  logic      out_valid_q, out_valid_d;
  out_word_t out_data_q, out_data_d;

  logic                     in_acc;
  logic [TIME_W-1:0]        rd_time;
  logic signed [TEMP_W-1:0] rd_temp;
  logic [FILL_W-1:0]        fill;

  alu_cmd_t alu_cmd;
  alu_rsp_t alu_rsp;
  logic     alu_st;
  logic     alu_go;

  logic [ACC_W-1:0] age_ext;
  logic [ACC_W-1:0] y_ext;
  logic [ACC_W-1:0] target_ext;
  logic [B_W-1:0]   n_b;
  logic             res_nonpos;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign age_ext    = ACC_W'(age_q);
  assign y_ext      = {{(ACC_W - TEMP_W){y_q[TEMP_W-1]}}, y_q};
  assign target_ext = {{(ACC_W - TEMP_W){target_q[TEMP_W-1]}}, target_q};
  assign n_b        = B_W'(fill);
  assign res_nonpos = alu_rsp.res[ACC_W-1] || (alu_rsp.res == '0);

  ttt_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk_i,
    .rst_ni,
    .wr_en_i   (in_acc),
    .wr_time_i (in_data_i.sample_time_ms),
    .wr_temp_i (in_data_i.temperature),
    .rd_idx_i  (idx_q),
    .rd_time_o (rd_time),
    .rd_temp_o (rd_temp),
    .fill_o    (fill)
  );

  ttt_alu u_alu (
    .clk_i,
    .rst_ni,
    .start_i (alu_go),
    .cmd_i   (alu_cmd),
    .rsp_o   (alu_rsp)
  );

  // Operand selection for the shared unit, one operation per state.
  // x = -age, so terms with x use the age magnitude and subtract.
  always_comb begin
    alu_st           = 1'b1;
    alu_cmd.op       = ALU_MAC;
    alu_cmd.a        = '0;
    alu_cmd.c        = '0;
    alu_cmd.b        = B_W'(1);
    alu_cmd.nb       = NB_W'(1);
    alu_cmd.b_signed = 1'b0;
    alu_cmd.neg      = 1'b0;
    unique case (state_q)
      ST_SX: begin
        alu_cmd.c   = sx_q;
        alu_cmd.a   = age_ext;
        alu_cmd.neg = 1'b1;
      end
      ST_SY: begin
        alu_cmd.c = sy_q;
        alu_cmd.a = y_ext;
      end
      ST_SXY: begin
        alu_cmd.c        = sxy_q;
        alu_cmd.a        = age_ext;
        alu_cmd.b        = y_ext[B_W-1:0];
        alu_cmd.nb       = NB_W'(TEMP_W);
        alu_cmd.b_signed = 1'b1;
        alu_cmd.neg      = 1'b1;
      end
      ST_SXX: begin
        alu_cmd.c  = sxx_q;
        alu_cmd.a  = age_ext;
        alu_cmd.b  = B_W'(age_q);
        alu_cmd.nb = NB_W'(TIME_W);
      end
      ST_NUM0: begin
        alu_cmd.a  = sxy_q;
        alu_cmd.b  = n_b;
        alu_cmd.nb = NB_W'(FILL_W);
      end
      ST_NUM1: begin
        alu_cmd.c        = num_q;
        alu_cmd.a        = sx_q;
        alu_cmd.b        = sy_q[B_W-1:0];
        alu_cmd.nb       = NB_W'(TN_NB);
        alu_cmd.b_signed = 1'b1;
        alu_cmd.neg      = 1'b1;
      end
      ST_D0: begin
        alu_cmd.a  = sxx_q;
        alu_cmd.b  = n_b;
        alu_cmd.nb = NB_W'(FILL_W);
      end
      ST_D1: begin
        alu_cmd.c        = den_q;
        alu_cmd.a        = sx_q;
        alu_cmd.b        = sx_q[B_W-1:0];
        alu_cmd.nb       = NB_W'(B_W);
        alu_cmd.b_signed = 1'b1;
        alu_cmd.neg      = 1'b1;
      end
      ST_CHK: begin
        alu_cmd.c  = den_q;
        alu_cmd.a  = num_q;
        alu_cmd.b  = B_W'(SLOPE_K);
        alu_cmd.nb = NB_W'(SLOPE_K_NB);
      end
      ST_TN0: begin
        alu_cmd.a   = sy_q;
        alu_cmd.neg = 1'b1;
      end
      ST_TN1: begin
        alu_cmd.c  = tn_q;
        alu_cmd.a  = target_ext;
        alu_cmd.b  = n_b;
        alu_cmd.nb = NB_W'(FILL_W);
      end
      ST_P0: begin
        alu_cmd.a        = den_q;
        alu_cmd.b        = tn_q[B_W-1:0];
        alu_cmd.nb       = NB_W'(TN_NB);
        alu_cmd.b_signed = 1'b1;
        alu_cmd.neg      = 1'b1;
      end
      ST_P1: begin
        alu_cmd.c        = p_q;
        alu_cmd.a        = num_q;
        alu_cmd.b        = sx_q[B_W-1:0];
        alu_cmd.nb       = NB_W'(B_W);
        alu_cmd.b_signed = 1'b1;
        alu_cmd.neg      = 1'b1;
      end
      ST_Q0: begin
        alu_cmd.a   = num_q;
        alu_cmd.b   = n_b;
        alu_cmd.nb  = NB_W'(FILL_W);
        alu_cmd.neg = 1'b1;
      end
      ST_Q1: begin
        alu_cmd.a  = q_q;
        alu_cmd.b  = B_W'(MS_PER_MIN);
        alu_cmd.nb = NB_W'(MS_MIN_NB);
      end
      ST_DIV: begin
        alu_cmd.op = ALU_DIV;
        alu_cmd.a  = p_q;
        alu_cmd.c  = q_q;
      end
      default: begin
        alu_st = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    idx_d       = idx_q;
    newest_d    = newest_q;
    age_d       = age_q;
    y_d         = y_q;
    minutes_d   = minutes_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sxy_d       = sxy_q;
    sxx_d       = sxx_q;
    num_d       = num_q;
    den_d       = den_q;
    tn_d        = tn_q;
    p_d         = p_q;
    q_d         = q_q;
    out_data_d  = out_data_q;
    alu_go      = 1'b0;

    // drop the result word once it is taken
    out_valid_d = out_valid_q && out_stall_i;

    if (alu_st && !issued_q) begin
      alu_go   = 1'b1;
      issued_d = 1'b1;
    end
    if (alu_rsp.done) begin
      issued_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          newest_d = in_data_i.sample_time_ms;
          sx_d     = '0;
          sy_d     = '0;
          sxy_d    = '0;
          sxx_d    = '0;
          idx_d    = '0;
          state_d  = ST_START;
        end
      end
      ST_START: begin
        if (fill >= FILL_W'(3)) begin
          state_d = ST_AGE;
        end else begin
          minutes_d = '0;
          state_d   = ST_OUT;
        end
      end
      ST_AGE: begin
        age_d   = newest_q - rd_time;
        y_d     = rd_temp;
        state_d = ST_SX;
      end
      ST_SX: begin
        if (alu_rsp.done) begin
          sx_d    = alu_rsp.res;
          state_d = ST_SY;
        end
      end
      ST_SY: begin
        if (alu_rsp.done) begin
          sy_d    = alu_rsp.res;
          state_d = ST_SXY;
        end
      end
      ST_SXY: begin
        if (alu_rsp.done) begin
          sxy_d   = alu_rsp.res;
          state_d = ST_SXX;
        end
      end
      ST_SXX: begin
        if (alu_rsp.done) begin
          sxx_d = alu_rsp.res;
          if (FILL_W'(idx_q) + FILL_W'(1) == fill) begin
            state_d = ST_NUM0;
          end else begin
            idx_d   = idx_q + SLOT_W'(1);
            state_d = ST_AGE;
          end
        end
      end
      ST_NUM0: begin
        if (alu_rsp.done) begin
          num_d   = alu_rsp.res;
          state_d = ST_NUM1;
        end
      end
      ST_NUM1: begin
        if (alu_rsp.done) begin
          num_d   = alu_rsp.res;
          state_d = ST_D0;
        end
      end
      ST_D0: begin
        if (alu_rsp.done) begin
          den_d   = alu_rsp.res;
          state_d = ST_D1;
        end
      end
      ST_D1: begin
        if (alu_rsp.done) begin
          den_d = alu_rsp.res;
          // degenerate fit: no spread in time
          if (res_nonpos) begin
            minutes_d = '0;
            state_d   = ST_OUT;
          end else begin
            state_d = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (alu_rsp.done) begin
          // slope not falling fast enough
          if (!alu_rsp.res[ACC_W-1]) begin
            minutes_d = '0;
            state_d   = ST_OUT;
          end else begin
            state_d = ST_TN0;
          end
        end
      end
      ST_TN0: begin
        if (alu_rsp.done) begin
          tn_d    = alu_rsp.res;
          state_d = ST_TN1;
        end
      end
      ST_TN1: begin
        if (alu_rsp.done) begin
          tn_d    = alu_rsp.res;
          state_d = ST_P0;
        end
      end
      ST_P0: begin
        if (alu_rsp.done) begin
          p_d     = alu_rsp.res;
          state_d = ST_P1;
        end
      end
      ST_P1: begin
        if (alu_rsp.done) begin
          p_d = alu_rsp.res;
          // target already passed or never reached
          if (res_nonpos) begin
            minutes_d = '0;
            state_d   = ST_OUT;
          end else begin
            state_d = ST_Q0;
          end
        end
      end
      ST_Q0: begin
        if (alu_rsp.done) begin
          q_d     = alu_rsp.res;
          state_d = ST_Q1;
        end
      end
      ST_Q1: begin
        if (alu_rsp.done) begin
          q_d     = alu_rsp.res;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (alu_rsp.done) begin
          minutes_d = alu_rsp.res[MIN_W-1:0];
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                  = 1'b1;
          out_data_d.estimate_valid    = (minutes_q != '0);
          out_data_d.minutes_to_target = minutes_q;
          out_data_d.samples_held      = HELD_W'(fill);
          state_d                      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      target_q    <= TARGET_RESET;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        target_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    newest_q   <= newest_d;
    age_q      <= age_d;
    y_q        <= y_d;
    minutes_q  <= minutes_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    sxy_q      <= sxy_d;
    sxx_q      <= sxx_d;
    num_q      <= num_d;
    den_q      <= den_d;
    tn_q       <= tn_d;
    p_q        <= p_d;
    q_q        <= q_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
